// ===== rtl/bsrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrd_pkg
// Shared types and constants of the byte-stuffed record deframer.
// ----------------------------------------------------------------------------
package bsrd_pkg;

  localparam int unsigned BUFFER_BYTES = 2048;
  localparam int unsigned ByteCntW     = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned OffW         = 12;

  localparam logic [7:0] SOF_BYTE   = 8'h5a;
  localparam logic [7:0] EOF_BYTE   = 8'h5b;
  localparam logic [7:0] ESC_BYTE   = 8'h5c;
  localparam logic [7:0] ESC_OFFSET = 8'h40;

  localparam logic [15:0] TYPE_PASSING = 16'hda09;
  localparam logic [15:0] TYPE_STATUS  = 16'hda0a;

  localparam logic [7:0] SIG_PILOT  = 8'h01;
  localparam logic [7:0] SIG_NUMBER = 8'h21;
  localparam logic [7:0] SIG_TIME   = 8'h02;

  localparam logic [7:0] SIZE_NUMBER = 8'd4;
  localparam logic [7:0] SIZE_TIME   = 8'd8;
  localparam logic [7:0] SIZE_VOLTS  = 8'd2;

  localparam logic [7:0] MAX_DATA_BYTES = 8'd8;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_SYNC,
    MODE_ESC
  } mode_t;

  typedef enum logic [1:0] {
    PH_SIG,
    PH_SIZE,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PILOT,
    KIND_NUMBER,
    KIND_TIME,
    KIND_VOLTS,
    KIND_FRAME_END,
    KIND_OVERFLOW
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] frame_type;
    logic [63:0] value;
  } result_t;

endpackage

// ===== rtl/bsrd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrd_core
// Frame state: unstuffing, header capture and record walk, one byte a cycle.
// ----------------------------------------------------------------------------
module bsrd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  output logic              res_valid,
  output bsrd_pkg::result_t res
);
  import bsrd_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [ByteCntW-1:0] byte_count_r, byte_count_nxt, byte_count_inc;
  logic [15:0]         length_word_r, length_word_nxt;
  logic [15:0]         type_word_r, type_word_nxt;
  phase_t              phase_r, phase_nxt;
  logic [7:0]          sig_r, sig_nxt;
  logic [7:0]          size_r, size_nxt;
  logic [7:0]          data_count_r, data_count_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [OffW-1:0]     offset_r, offset_nxt;

  logic                store;
  logic [7:0]          sbyte;
  logic                do_finish;
  logic                walk_type;

  assign byte_count_inc = byte_count_r + ByteCntW'(1);

  always_comb begin
    mode_nxt        = mode_r;
    byte_count_nxt  = byte_count_r;
    length_word_nxt = length_word_r;
    type_word_nxt   = type_word_r;
    phase_nxt       = phase_r;
    sig_nxt         = sig_r;
    size_nxt        = size_r;
    data_count_nxt  = data_count_r;
    acc_nxt         = acc_r;
    offset_nxt      = offset_r;
    store           = 1'b0;
    sbyte           = byte_data;
    do_finish       = 1'b0;
    walk_type       = 1'b0;
    res_valid       = 1'b0;
    res.kind        = KIND_PILOT;
    res.value       = 64'd0;

    if (byte_valid) begin
      unique case (mode_r)
        MODE_HUNT: begin
          if (byte_data == SOF_BYTE) begin
            mode_nxt        = MODE_SYNC;
            byte_count_nxt  = '0;
            length_word_nxt = '0;
            type_word_nxt   = '0;
            phase_nxt       = PH_SIG;
            sig_nxt         = '0;
            size_nxt        = '0;
            data_count_nxt  = '0;
            acc_nxt         = '0;
            offset_nxt      = '0;
          end
        end
        MODE_SYNC: begin
          if (byte_data == EOF_BYTE) begin
            res_valid = 1'b1;
            res.kind  = KIND_FRAME_END;
            res.value = 64'(length_word_r);
            mode_nxt  = MODE_HUNT;
          end else if (byte_data == ESC_BYTE) begin
            mode_nxt = MODE_ESC;
          end else begin
            store = 1'b1;
          end
        end
        MODE_ESC: begin
          store    = 1'b1;
          sbyte    = byte_data - ESC_OFFSET;
          mode_nxt = MODE_SYNC;
        end
        default: begin
          mode_nxt = MODE_HUNT;
        end
      endcase

      if (store) begin
        priority if (byte_count_r == ByteCntW'(0)) begin
          length_word_nxt[7:0] = sbyte;
        end else if (byte_count_r == ByteCntW'(1)) begin
          length_word_nxt[15:8] = sbyte;
        end else if (byte_count_r == ByteCntW'(4)) begin
          type_word_nxt[7:0] = sbyte;
        end else if (byte_count_r == ByteCntW'(5)) begin
          type_word_nxt[15:8] = sbyte;
        end else if (byte_count_r >= ByteCntW'(6)) begin
          walk_type = (type_word_r == TYPE_PASSING) || (type_word_r == TYPE_STATUS);
          unique case (phase_r)
            PH_SIG: begin
              if (walk_type && ((16'(offset_r) + 16'd8) < length_word_r)) begin
                sig_nxt   = sbyte;
                phase_nxt = PH_SIZE;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_SIZE: begin
              size_nxt       = sbyte;
              data_count_nxt = '0;
              acc_nxt        = '0;
              if (sbyte == 8'd0) begin
                do_finish = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              if (data_count_r < MAX_DATA_BYTES) begin
                acc_nxt = acc_r | (64'(sbyte) << {data_count_r[2:0], 3'b000});
              end
              data_count_nxt = data_count_r + 8'd1;
              if (data_count_nxt == size_r) begin
                do_finish = 1'b1;
              end
            end
            PH_DONE: begin
              phase_nxt = PH_DONE;
            end
          endcase
        end else begin
          length_word_nxt = length_word_r;
        end

        if (do_finish) begin
          if (type_word_r == TYPE_PASSING) begin
            priority if (sig_nxt == SIG_PILOT) begin
              res_valid = 1'b1;
              res.kind  = KIND_PILOT;
              res.value = {56'd0, acc_nxt[7:0]};
            end else if (sig_nxt == SIG_NUMBER && size_nxt == SIZE_NUMBER) begin
              res_valid = 1'b1;
              res.kind  = KIND_NUMBER;
              res.value = acc_nxt;
            end else if (sig_nxt == SIG_TIME && size_nxt == SIZE_TIME) begin
              res_valid = 1'b1;
              res.kind  = KIND_TIME;
              res.value = acc_nxt;
            end else begin
              res_valid = 1'b0;
            end
          end else if (type_word_r == TYPE_STATUS) begin
            if (sig_nxt == SIG_NUMBER && size_nxt == SIZE_VOLTS) begin
              res_valid = 1'b1;
              res.kind  = KIND_VOLTS;
              res.value = acc_nxt;
            end
          end
          offset_nxt = offset_r + OffW'(size_nxt) + OffW'(2);
          phase_nxt  = PH_SIG;
        end

        byte_count_nxt = byte_count_inc;
        if (byte_count_inc == ByteCntW'(BUFFER_BYTES)) begin
          mode_nxt       = MODE_HUNT;
          byte_count_nxt = '0;
          res_valid      = 1'b1;
          res.kind       = KIND_OVERFLOW;
          res.value      = 64'd0;
        end
      end
    end

    res.frame_type = type_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_HUNT;
      byte_count_r  <= '0;
      length_word_r <= '0;
      type_word_r   <= '0;
      phase_r       <= PH_SIG;
      sig_r         <= '0;
      size_r        <= '0;
      data_count_r  <= '0;
      acc_r         <= '0;
      offset_r      <= '0;
    end else begin
      mode_r        <= mode_nxt;
      byte_count_r  <= byte_count_nxt;
      length_word_r <= length_word_nxt;
      type_word_r   <= type_word_nxt;
      phase_r       <= phase_nxt;
      sig_r         <= sig_nxt;
      size_r        <= size_nxt;
      data_count_r  <= data_count_nxt;
      acc_r         <= acc_nxt;
      offset_r      <= offset_nxt;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r < ByteCntW'(BUFFER_BYTES))
    else $error("byte count reached buffer size");

  a_overflow_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_OVERFLOW) |=> (mode_r == MODE_HUNT && byte_count_r == '0))
    else $error("overflow did not return to hunting");

  a_data_phase_size: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (size_r != 8'd0 && data_count_r < size_r))
    else $error("record data count out of range");

  a_frame_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_FRAME_END) |=> (mode_r == MODE_HUNT))
    else $error("frame end did not return to hunting");

endmodule

// ===== rtl/bsrd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrd_out_buf
// Two-entry result buffer that parts the core from output back-pressure.
// ----------------------------------------------------------------------------
module bsrd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  bsrd_pkg::result_t wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_stall,
  output bsrd_pkg::result_t rd_data
);
  import bsrd_pkg::*;

  result_t     entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        rd_en;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign rd_en    = rd_valid && !rd_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt  = count_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en)
    else $error("write into full result buffer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("result buffer count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("result buffer pointers disagree with count");

endmodule

// ===== rtl/byte_stuffed_record_deframer.sv =====
`timescale 1ns / 1ps
// an accepted byte is held in the input register; its result is then written into the result buffer, which drives out_
// throughput: one byte per cycle, sustained while out_stall stays low
// the input register holds while the two-entry result buffer is full
// reset: synchronous active-low rst_n; returns to hunting for the start byte,
// clears the frame state and empties the result buffer
// ----------------------------------------------------------------------------
// byte_stuffed_record_deframer
// Unstuffs framed serial bytes and reports record values and frame events.
// ----------------------------------------------------------------------------
module byte_stuffed_record_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [15:0] out_frame_type,
  output logic [63:0] out_value
);
  import bsrd_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       buf_full;
  logic       proc;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign proc     = in_valid_r && !buf_full;
  assign in_stall = in_valid_r && buf_full;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  bsrd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(proc),
    .byte_data (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  bsrd_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (buf_full),
    .rd_valid(out_valid),
    .rd_stall(out_stall),
    .rd_data (out_data)
  );

  assign out_kind       = out_data.kind;
  assign out_frame_type = out_data.frame_type;
  assign out_value      = out_data.value;

endmodule

// ===== tb/bsrd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrd_checker
// Watches both channels of the deframer, predicts each result from the
// accepted link bytes and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module bsrd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [15:0] out_frame_type,
  input  logic [63:0] out_value,
  output int          fail_count,
  output int          outstanding
);
  import bsrd_pkg::*;

  mode_t       fr_mode;
  int unsigned stored_cnt;
  logic [15:0] len_word;
  logic [15:0] typ_word;
  phase_t      rec_phase;
  logic [7:0]  rec_sig;
  logic [7:0]  rec_size;
  logic [7:0]  rec_cnt;
  logic [63:0] rec_acc;
  logic [11:0] rec_offset;

  logic        res_hit;
  kind_t       res_kind;
  logic [63:0] res_val;

  result_t     expected_results[$];

  task automatic clear_frame;
    stored_cnt = 0;
    len_word   = '0;
    typ_word   = '0;
    rec_phase  = PH_SIG;
    rec_sig    = '0;
    rec_size   = '0;
    rec_cnt    = '0;
    rec_acc    = '0;
    rec_offset = '0;
  endtask

  task automatic flag_result(input kind_t k, input logic [63:0] v);
    res_hit  = 1'b1;
    res_kind = k;
    res_val  = v;
  endtask

  task automatic close_record;
    if (typ_word == TYPE_PASSING) begin
      if (rec_sig == SIG_PILOT)
        flag_result(KIND_PILOT, {56'd0, rec_acc[7:0]});
      else if (rec_sig == SIG_NUMBER && rec_size == SIZE_NUMBER)
        flag_result(KIND_NUMBER, rec_acc);
      else if (rec_sig == SIG_TIME && rec_size == SIZE_TIME)
        flag_result(KIND_TIME, rec_acc);
    end else if (typ_word == TYPE_STATUS) begin
      if (rec_sig == SIG_NUMBER && rec_size == SIZE_VOLTS)
        flag_result(KIND_VOLTS, rec_acc);
    end
    rec_offset = 12'(rec_offset + rec_size + 2);
    rec_phase  = PH_SIG;
  endtask

  task automatic store_byte(input logic [7:0] b);
    case (stored_cnt)
      0: len_word[7:0] = b;
      1: len_word[15:8] = b;
      4: typ_word[7:0] = b;
      5: typ_word[15:8] = b;
      default: begin
        if (stored_cnt >= 6) begin
          case (rec_phase)
            PH_SIG: begin
              if ((typ_word == TYPE_PASSING || typ_word == TYPE_STATUS) &&
                  rec_offset + 8 < len_word) begin
                rec_sig   = b;
                rec_phase = PH_SIZE;
              end else begin
                rec_phase = PH_DONE;
              end
            end
            PH_SIZE: begin
              rec_size = b;
              rec_cnt  = '0;
              rec_acc  = '0;
              if (b == 8'd0)
                close_record;
              else
                rec_phase = PH_DATA;
            end
            PH_DATA: begin
              if (rec_cnt < MAX_DATA_BYTES)
                rec_acc[8*rec_cnt +: 8] = b;
              rec_cnt = rec_cnt + 8'd1;
              if (rec_cnt == rec_size)
                close_record;
            end
            default: ;
          endcase
        end
      end
    endcase
    stored_cnt = stored_cnt + 1;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    result_t r;
    res_hit = 1'b0;
    case (fr_mode)
      MODE_HUNT: begin
        if (b == SOF_BYTE) begin
          fr_mode = MODE_SYNC;
          clear_frame;
        end
      end
      MODE_SYNC: begin
        if (b == EOF_BYTE) begin
          flag_result(KIND_FRAME_END, {48'd0, len_word});
          fr_mode = MODE_HUNT;
        end else if (b == ESC_BYTE) begin
          fr_mode = MODE_ESC;
        end else begin
          store_byte(b);
        end
      end
      default: begin
        store_byte(b - ESC_OFFSET);
        fr_mode = MODE_SYNC;
      end
    endcase
    // overflow replaces any record result of the same byte
    if (stored_cnt >= BUFFER_BYTES) begin
      fr_mode    = MODE_HUNT;
      stored_cnt = 0;
      flag_result(KIND_OVERFLOW, 64'd0);
    end
    if (res_hit) begin
      r.kind       = res_kind;
      r.frame_type = typ_word;
      r.value      = res_val;
      expected_results.push_back(r);
      outstanding = outstanding + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      fr_mode = MODE_HUNT;
      clear_frame;
      expected_results.delete();
      outstanding = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d, frame_type %h, value %h",
                 out_kind, out_frame_type, out_value);
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          outstanding = outstanding - 1;
          if (out_kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
            fail_count = fail_count + 1;
          end
          if (out_frame_type !== want.frame_type) begin
            $error("frame_type mismatch: expected %h, actual %h",
                   want.frame_type, out_frame_type);
            fail_count = fail_count + 1;
          end
          if (out_value !== want.value) begin
            $error("value mismatch: expected %h, actual %h", want.value, out_value);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/byte_stuffed_record_deframer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_record_deframer_test
// Sends stuffed frames of records, stray bytes, short and overflowing frames
// to the deframer under random sender and receiver idling; results are
// checked by bsrd_checker.
// ----------------------------------------------------------------------------
module byte_stuffed_record_deframer_test;
  import bsrd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_frame_type;
  logic [63:0] out_value;

  int fail_total;
  int pending_total;

  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         sent_items = 0;
  int         quiet_cycles = 0;
  bit         long_hold_req = 1'b0;
  int         hold_cnt = 0;
  logic [7:0] tx_q[$];

  byte_stuffed_record_deframer uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_frame_type(out_frame_type),
    .out_value     (out_value)
  );

  bsrd_checker results_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_frame_type(out_frame_type),
    .out_value     (out_value),
    .fail_count    (fail_total),
    .outstanding   (pending_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver side, including the long hold-off
  always @(negedge clk) begin
    if (long_hold_req && hold_cnt < LONG_HOLD) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic put_raw(input logic [7:0] b);
    tx_q.push_back(b);
  endtask

  task automatic put_data(input logic [7:0] v);
    if (v == EOF_BYTE || v == ESC_BYTE || $urandom_range(7) == 0) begin
      put_raw(ESC_BYTE);
      put_raw(v + ESC_OFFSET);
    end else begin
      put_raw(v);
    end
  endtask

  task automatic put_word(input logic [15:0] w);
    put_data(w[7:0]);
    put_data(w[15:8]);
  endtask

  task automatic put_record(input logic [7:0] sig, input logic [7:0] size, input bit ones);
    put_data(sig);
    put_data(size);
    repeat (size) put_data(ones ? 8'hff : 8'($urandom_range(0, 255)));
  endtask

  task automatic flush_tx;
    logic [7:0] b;
    while (tx_q.size() != 0) begin
      b = tx_q.pop_front();
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= b;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
      sent_items = sent_items + 1;
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained;
    while (pending_total != 0) @(negedge clk);
  endtask

  task automatic put_random_frame;
    logic [7:0]  sigs[4];
    logic [7:0]  sizes[4];
    logic [15:0] typ;
    logic [15:0] len;
    int          nrec;
    int          body;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // line noise between frames
      repeat ($urandom_range(1, 4)) put_raw(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 16) begin
      // frame cut off before its header is complete
      put_raw(SOF_BYTE);
      repeat ($urandom_range(0, 5)) put_data(8'($urandom_range(0, 255)));
      put_raw(EOF_BYTE);
      return;
    end
    pick = $urandom_range(99);
    if (pick < 45)
      typ = TYPE_PASSING;
    else if (pick < 85)
      typ = TYPE_STATUS;
    else
      typ = 16'($urandom_range(0, 65535));
    nrec = $urandom_range(0, 4);
    body = 0;
    for (int i = 0; i < nrec; i++) begin
      pick = $urandom_range(99);
      sigs[i]  = 8'($urandom_range(0, 255));
      sizes[i] = 8'($urandom_range(0, 12));
      if (typ == TYPE_PASSING) begin
        if (pick < 25) begin
          sigs[i] = SIG_PILOT;
        end else if (pick < 45) begin
          sigs[i]  = SIG_NUMBER;
          sizes[i] = SIZE_NUMBER;
        end else if (pick < 65) begin
          sigs[i]  = SIG_TIME;
          sizes[i] = SIZE_TIME;
        end else if (pick < 80) begin
          sigs[i] = (pick < 72) ? SIG_NUMBER : SIG_TIME;
        end
      end else if (typ == TYPE_STATUS) begin
        if (pick < 55) begin
          sigs[i]  = SIG_NUMBER;
          sizes[i] = SIZE_VOLTS;
        end else if (pick < 75) begin
          sigs[i]  = SIG_NUMBER;
          sizes[i] = 8'($urandom_range(0, 6));
        end
      end
      body = body + sizes[i] + 2;
    end
    pick = $urandom_range(99);
    if (pick < 70)
      len = 16'(body + 8 + $urandom_range(0, 4));
    else if (pick < 85)
      len = 16'(body + 6);
    else if (pick < 93)
      len = 16'($urandom_range(0, 12));
    else
      len = 16'($urandom_range(0, 65535));
    put_raw(SOF_BYTE);
    put_word(len);
    put_word(16'($urandom_range(0, 65535)));
    put_word(typ);
    for (int i = 0; i < nrec; i++)
      put_record(sigs[i], sizes[i], 1'b0);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) put_data(8'($urandom_range(0, 255)));
    if ($urandom_range(19) != 0)
      put_raw(EOF_BYTE);
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      put_random_frame;
      flush_tx;
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 24;
    rx_idle_pct = 63;

    // stray bytes while hunting
    put_raw(EOF_BYTE);
    put_raw(ESC_BYTE);
    put_raw(8'h00);
    // empty and short frames
    put_raw(SOF_BYTE);
    put_raw(EOF_BYTE);
    put_raw(SOF_BYTE);
    put_raw(8'hff);
    put_raw(EOF_BYTE);
    // passing frame: empty pilot, number, all-ones time, long pilot, start byte as data
    put_raw(SOF_BYTE);
    put_word(16'h0040);
    put_word({EOF_BYTE, ESC_BYTE});
    put_word(TYPE_PASSING);
    put_record(SIG_PILOT, 8'd0, 1'b0);
    put_record(SIG_NUMBER, SIZE_NUMBER, 1'b0);
    put_record(SIG_TIME, SIZE_TIME, 1'b1);
    put_record(SIG_PILOT, 8'd10, 1'b1);
    put_raw(SOF_BYTE);
    put_raw(EOF_BYTE);
    // status frame with a voltage record
    put_raw(SOF_BYTE);
    put_word(16'hffff);
    put_word(16'h0000);
    put_word(TYPE_STATUS);
    put_record(SIG_NUMBER, SIZE_VOLTS, 1'b1);
    put_raw(EOF_BYTE);
    flush_tx;

    // overflow lands on the last data byte of a pilot record
    put_raw(SOF_BYTE);
    put_word(16'hffff);
    put_word(16'($urandom_range(0, 65535)));
    put_word(TYPE_PASSING);
    repeat (7) put_record(SIG_PILOT, 8'd255, 1'b0);
    put_record(SIG_PILOT, 8'd241, 1'b0);
    put_raw(EOF_BYTE);
    flush_tx;
    wait_drained;

    run_random(185);
    wait_drained;

    tx_idle_pct = 63;
    rx_idle_pct = 24;
    run_random(185);
    wait_drained;

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_req = 1'b1;
    repeat (8) put_random_frame;
    flush_tx;
    wait_drained;
    run_random(185);
    wait_drained;

    repeat (10) @(negedge clk);
    if (fail_total == 0 && pending_total == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bsrd_pkg.sv
rtl/bsrd_core.sv
rtl/bsrd_out_buf.sv
rtl/byte_stuffed_record_deframer.sv
tb/bsrd_checker.sv
tb/byte_stuffed_record_deframer_test.sv
